### design/cluster_chain_allocator_defines.svh
// ----------------------------------------------------------------------------
// Cluster chain allocator assertion macros
// Shared assertion forms for the cluster chain allocator design files.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH
`define CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cca_pkg.sv
// ----------------------------------------------------------------------------
// Cluster chain allocator package
// Request and response types, command and status codes, register indexes
// and sequencer states shared by the cluster chain allocator files.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int MAX_CLUSTERS_DEF = 4096;

    localparam int MAP_BIT_W = 4;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE_SECTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER       = 2'd2;

    localparam logic [11:0] CLUSTER_COUNT_RST = 12'd4095;
    localparam logic [31:0] DATA_BASE_RST     = 32'd0;
    localparam logic [31:0] END_MARKER_RST    = 32'h0FFF_FFFF;

    localparam logic [2:0] MODE_ALLOC  = 3'd0;
    localparam logic [2:0] MODE_FREE   = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_WRITE  = 3'd3;
    localparam logic [2:0] MODE_SECTOR = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] cluster;
        logic [11:0] prev_cluster;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ALLOC_LINK,
        ST_FREE_CHK,
        ST_FREE_WAIT,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

endpackage

### design/cluster_chain_allocator.sv
// ----------------------------------------------------------------------------
// Cluster chain allocator
// Keeps a table of next-cluster links and a free map and runs one chain
// command per request: allocate, free chain, read entry, write entry, or
// map a cluster to a sector.
//
// Requests arrive on the s_ channel and each gives exactly one response on
// the m_ channel. Registers are to be written on the cfg_ channel while the
// block is idle; the block itself does not enforce this. One request is
// handled at a time; s_ready is high only in idle. Allocate scans the free
// map one word of 16 clusters at a time and links the new cluster after
// another when one is given. Free chain walks the chain through the link
// table and clears each cluster in the free map. Read entry reads the link
// table; other commands and rejected requests answer from the decode step.
// After reset a clearing pass zeroes the link table and the free map, but
// marks the first cluster in use, before the first request is taken.
// The response waits in an output register; the next request is accepted
// while it waits, and only the hand-off of a new response stalls.
// ----------------------------------------------------------------------------
`include "cluster_chain_allocator_defines.svh"

module cluster_chain_allocator #(
    parameter int MAX_CLUSTERS = cca_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cca_pkg::req_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cca_pkg::rsp_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int IDX_W     = $clog2(MAX_CLUSTERS);
    localparam int CNT_W     = $clog2(MAX_CLUSTERS + 1);
    localparam int CW        = (CNT_W > 12) ? CNT_W : 12;
    localparam int BIT_W     = cca_pkg::MAP_BIT_W;
    localparam int MAP_W     = 1 << BIT_W;
    localparam int MAP_DEPTH = (MAX_CLUSTERS + MAP_W - 1) / MAP_W;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    cca_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    cca_pkg::req_t     req_reg, req_next;
    logic [MAP_AW-1:0] word_reg, word_next;
    logic [IDX_W-1:0]  alloc_reg, alloc_next;
    logic [31:0]       cur_reg, cur_next;
    logic [CW-1:0]     freed_reg, freed_next;
    logic [31:0]       res_reg, res_next;
    logic [1:0]        sts_reg, sts_next;
    logic              m_valid_reg, m_valid_next;
    cca_pkg::rsp_t     m_data_reg, m_data_next;
    logic [11:0]       cc_reg;
    logic [31:0]       dbs_reg;
    logic [31:0]       endm_reg;

    logic              lt_we;
    logic [IDX_W-1:0]  lt_waddr;
    logic [31:0]       lt_wdata;
    logic [IDX_W-1:0]  lt_raddr;
    logic [31:0]       lt_rdata;
    logic              um_we;
    logic [MAP_AW-1:0] um_waddr;
    logic [MAP_W-1:0]  um_wdata;
    logic [MAP_AW-1:0] um_raddr;
    logic [MAP_W-1:0]  um_rdata;

    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     cc_ext;
    logic [CW-1:0]     n_m1;
    logic [CW-1:0]     last_ext;
    logic [MAP_AW-1:0] last_word;
    logic [CW-1:0]     cl_m1;
    logic [CW-1:0]     prev_m1;
    logic [31:0]       cur_m1;
    logic [IDX_W-1:0]  cl_idx;
    logic [IDX_W-1:0]  prev_idx;
    logic [IDX_W-1:0]  cur_idx;
    logic              cl_valid;
    logic              prev_valid;
    logic              cur_valid;
    logic [CW-1:0]     word_base;
    logic [CW-1:0]     word_rem;
    logic [MAP_W-1:0]  free_vec;
    logic              found;
    logic [BIT_W-1:0]  found_bit;
    logic [MAP_AW+BIT_W-1:0] found_glob;
    logic              out_load;

    function automatic logic is_valid(input logic [31:0] x, input logic [CW-1:0] n);
        return (x != 32'd0) && (x <= 32'(n));
    endfunction

    function automatic logic [MAP_AW-1:0] map_word(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] t;
        t = {1'b0, idx} >> BIT_W;
        return t[MAP_AW-1:0];
    endfunction

    cca_ram #(
        .DEPTH (MAX_CLUSTERS),
        .WIDTH (32),
        .AW    (IDX_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (lt_we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .raddr (lt_raddr),
        .rdata (lt_rdata)
    );

    cca_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (MAP_W),
        .AW    (MAP_AW)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (um_we),
        .waddr (um_waddr),
        .wdata (um_wdata),
        .raddr (um_raddr),
        .rdata (um_rdata)
    );

    always_comb begin
        cc_ext    = CW'(cc_reg);
        n_cnt     = (cc_ext < CW'(MAX_CLUSTERS)) ? cc_ext : CW'(MAX_CLUSTERS);
        n_m1      = n_cnt - CW'(1);
        last_ext  = n_m1 >> BIT_W;
        last_word = last_ext[MAP_AW-1:0];

        cl_m1    = CW'(req_reg.cluster) - CW'(1);
        prev_m1  = CW'(req_reg.prev_cluster) - CW'(1);
        cur_m1   = cur_reg - 32'd1;
        cl_idx   = cl_m1[IDX_W-1:0];
        prev_idx = prev_m1[IDX_W-1:0];
        cur_idx  = cur_m1[IDX_W-1:0];

        cl_valid   = is_valid(32'(req_reg.cluster), n_cnt);
        prev_valid = is_valid(32'(req_reg.prev_cluster), n_cnt);
        cur_valid  = is_valid(cur_reg, n_cnt);

        word_base = CW'({word_reg, {BIT_W{1'b0}}});
        word_rem  = n_cnt - word_base;
        for (int b = 0; b < MAP_W; b++) begin
            free_vec[b] = !um_rdata[b] && (CW'(b) < word_rem);
        end
        found     = 1'b0;
        found_bit = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                found     = 1'b1;
                found_bit = BIT_W'(b);
            end
        end
        found_glob = {word_reg, found_bit};
    end

    assign s_ready   = (state_reg == cca_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_load  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cca_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        word_reg   <= word_next;
        alloc_reg  <= alloc_next;
        cur_reg    <= cur_next;
        freed_reg  <= freed_next;
        res_reg    <= res_next;
        sts_reg    <= sts_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg   <= cca_pkg::CLUSTER_COUNT_RST;
            dbs_reg  <= cca_pkg::DATA_BASE_RST;
            endm_reg <= cca_pkg::END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cca_pkg::CFG_CLUSTER_COUNT:    cc_reg   <= cfg_data[11:0];
                cca_pkg::CFG_DATA_BASE_SECTOR: dbs_reg  <= cfg_data;
                cca_pkg::CFG_END_MARKER:       endm_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        req_next     = req_reg;
        word_next    = word_reg;
        alloc_next   = alloc_reg;
        cur_next     = cur_reg;
        freed_next   = freed_reg;
        res_next     = res_reg;
        sts_next     = sts_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        lt_we    = 1'b0;
        lt_waddr = cl_idx;
        lt_wdata = endm_reg;
        lt_raddr = cl_idx;
        um_we    = 1'b0;
        um_waddr = word_reg;
        um_wdata = um_rdata;
        um_raddr = word_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cca_pkg::ST_CLEAR: begin
                lt_we    = 1'b1;
                lt_waddr = clr_reg;
                lt_wdata = 32'd0;
                if (clr_reg < IDX_W'(MAP_DEPTH)) begin
                    um_we    = 1'b1;
                    um_waddr = clr_reg[MAP_AW-1:0];
                    um_wdata = (clr_reg == '0) ? MAP_W'(1) : '0;
                end
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_CLUSTERS - 1)) begin
                    state_next = cca_pkg::ST_IDLE;
                end
            end
            cca_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    res_next   = 32'd0;
                    sts_next   = cca_pkg::STATUS_OK;
                    state_next = cca_pkg::ST_DECODE;
                end
            end
            cca_pkg::ST_DECODE: begin
                state_next = cca_pkg::ST_DONE;
                unique case (req_reg.mode)
                    cca_pkg::MODE_ALLOC: begin
                        if (req_reg.cluster != 12'd0 && !cl_valid) begin
                            sts_next = cca_pkg::STATUS_BAD;
                        end else if (n_cnt == '0) begin
                            sts_next = cca_pkg::STATUS_NO_FREE;
                        end else begin
                            word_next  = '0;
                            state_next = cca_pkg::ST_SCAN_RD;
                        end
                    end
                    cca_pkg::MODE_FREE: begin
                        if (req_reg.prev_cluster != 12'd0 && !prev_valid) begin
                            sts_next = cca_pkg::STATUS_BAD;
                        end else begin
                            cur_next   = 32'(req_reg.cluster);
                            freed_next = '0;
                            state_next = cca_pkg::ST_FREE_CHK;
                        end
                    end
                    cca_pkg::MODE_READ: begin
                        if (cl_valid) begin
                            lt_raddr   = cl_idx;
                            state_next = cca_pkg::ST_READ_WAIT;
                        end else begin
                            sts_next = cca_pkg::STATUS_BAD;
                        end
                    end
                    cca_pkg::MODE_WRITE: begin
                        if (cl_valid) begin
                            lt_we    = 1'b1;
                            lt_waddr = cl_idx;
                            lt_wdata = req_reg.entry_value;
                        end else begin
                            sts_next = cca_pkg::STATUS_BAD;
                        end
                    end
                    cca_pkg::MODE_SECTOR: begin
                        if (cl_valid) begin
                            res_next = dbs_reg + 32'(req_reg.cluster) - 32'd1;
                        end else begin
                            sts_next = cca_pkg::STATUS_BAD;
                        end
                    end
                    default: begin
                        sts_next = cca_pkg::STATUS_BAD;
                    end
                endcase
            end
            cca_pkg::ST_SCAN_RD: begin
                um_raddr   = word_reg;
                state_next = cca_pkg::ST_SCAN_CHK;
            end
            cca_pkg::ST_SCAN_CHK: begin
                if (found) begin
                    alloc_next = found_glob[IDX_W-1:0];
                    um_we      = 1'b1;
                    um_waddr   = word_reg;
                    um_wdata   = um_rdata | (MAP_W'(1) << found_bit);
                    lt_we      = 1'b1;
                    lt_waddr   = found_glob[IDX_W-1:0];
                    lt_wdata   = endm_reg;
                    res_next   = 32'(found_glob) + 32'd1;
                    if (req_reg.cluster != 12'd0) begin
                        state_next = cca_pkg::ST_ALLOC_LINK;
                    end else begin
                        state_next = cca_pkg::ST_DONE;
                    end
                end else if (word_reg == last_word) begin
                    sts_next   = cca_pkg::STATUS_NO_FREE;
                    state_next = cca_pkg::ST_DONE;
                end else begin
                    word_next  = word_reg + MAP_AW'(1);
                    state_next = cca_pkg::ST_SCAN_RD;
                end
            end
            cca_pkg::ST_ALLOC_LINK: begin
                lt_we      = 1'b1;
                lt_waddr   = cl_idx;
                lt_wdata   = 32'(alloc_reg) + 32'd1;
                state_next = cca_pkg::ST_DONE;
            end
            cca_pkg::ST_FREE_CHK: begin
                if (cur_reg == endm_reg) begin
                    if (req_reg.prev_cluster != 12'd0) begin
                        lt_we    = 1'b1;
                        lt_waddr = prev_idx;
                        lt_wdata = endm_reg;
                    end
                    state_next = cca_pkg::ST_DONE;
                end else if (!cur_valid || freed_reg >= n_cnt) begin
                    sts_next   = cca_pkg::STATUS_BAD;
                    state_next = cca_pkg::ST_DONE;
                end else begin
                    lt_raddr   = cur_idx;
                    um_raddr   = map_word(cur_idx);
                    state_next = cca_pkg::ST_FREE_WAIT;
                end
            end
            cca_pkg::ST_FREE_WAIT: begin
                um_we      = 1'b1;
                um_waddr   = map_word(cur_idx);
                um_wdata   = um_rdata & ~(MAP_W'(1) << cur_idx[BIT_W-1:0]);
                cur_next   = lt_rdata;
                freed_next = freed_reg + CW'(1);
                state_next = cca_pkg::ST_FREE_CHK;
            end
            cca_pkg::ST_READ_WAIT: begin
                res_next   = lt_rdata;
                state_next = cca_pkg::ST_DONE;
            end
            cca_pkg::ST_DONE: begin
                if (out_load) begin
                    m_valid_next             = 1'b1;
                    m_data_next.result_value = res_reg;
                    m_data_next.status       = sts_reg;
                    state_next               = cca_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cca_pkg::ST_IDLE;
            end
        endcase
    end

    `CCA_ASSERT_SAME(a_clear_blocks, aclk, aresetn, state_reg == cca_pkg::ST_CLEAR, !s_ready, "request taken in clear")
    `CCA_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == cca_pkg::ST_DECODE, "no decode")
    `CCA_ASSERT_SAME(a_walk_bound, aclk, aresetn, state_reg == cca_pkg::ST_FREE_CHK, freed_reg <= n_cnt, "walk overrun")
    `CCA_ASSERT_SAME(a_scan_range, aclk, aresetn, state_reg == cca_pkg::ST_SCAN_CHK, word_reg <= last_word, "scan overrun")
    `CCA_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid_reg, m_data_reg.status <= cca_pkg::STATUS_BAD, "bad status")

endmodule

### design/cca_ram.sv
// ----------------------------------------------------------------------------
// Cluster chain allocator RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
